[hw/rtl/tqpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqpr_pkg
// Shared types, sizes and helpers for the two-queue page replacement block.
// ----------------------------------------------------------------------------
package tqpr_pkg;

  // Entries per list. The circular lists wrap by masking, so this stays a
  // power of two.
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int FILL_W     = IDX_W + 1;
  localparam int CAP_W      = 6;
  localparam int PAGE_W     = 32;
  localparam int CNT_W      = 32;
  localparam int MEM_DEPTH  = 3 * LIST_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(2 * LIST_DEPTH);

  // Where a page was found; also selects the list region of the memory.
  typedef enum logic [1:0] {
    LOC_MAIN  = 2'd0,
    LOC_FIFO  = 2'd1,
    LOC_GHOST = 2'd2,
    LOC_NONE  = 2'd3
  } loc_t;

  function automatic logic [MEM_AW-1:0] mem_addr(input loc_t list,
                                                 input logic [IDX_W-1:0] idx);
    mem_addr = MEM_AW'(MEM_AW'(list) * MEM_AW'(LIST_DEPTH) + MEM_AW'(idx));
  endfunction

endpackage

[hw/rtl/tqpr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqpr_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tqpr_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/two_queue_page_replacement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_page_replacement
// Simplified 2Q replacement tracker with main, first-in and ghost lists.
// ----------------------------------------------------------------------------
// All three lists share one single-port-read RAM, so the lookup reads and
// compares each stored entry of the main, first-in and ghost lists in turn.
// A main or ghost hit closes its gap, and a full main list drops its oldest
// page, by moving each later entry down one slot with a read and a write.
// Decision, first-in retirement, write-back and result follow. One access
// is processed at a time; the result register lets the next access start
// while a result waits, and the final step stalls only while that register
// still holds an untaken result. The input is stalled while a capacity
// write is offered.
// ----------------------------------------------------------------------------
module two_queue_page_replacement (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tqpr_pkg::PAGE_W-1:0]  in_page,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [1:0]                   out_found_in,
  output logic [tqpr_pkg::CNT_W-1:0]   out_hit_total,
  output logic [tqpr_pkg::CNT_W-1:0]   out_miss_total,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tqpr_pkg::CAP_W-1:0]   cfg_data
);
  import tqpr_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SC_RD  = 10'b0000000010,
    ST_SC_CMP = 10'b0000000100,
    ST_ACT    = 10'b0000001000,
    ST_SH_RD  = 10'b0000010000,
    ST_SH_WR  = 10'b0000100000,
    ST_FI_RD  = 10'b0001000000,
    ST_FI_WR  = 10'b0010000000,
    ST_FIN    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  // What follows the end of a shift pass.
  typedef enum logic [1:0] {
    AFT_MAIN_FIN = 2'd0,
    AFT_GHOST    = 2'd1,
    AFT_EVICT    = 2'd2
  } aft_t;

  state_t              state_r, state_nxt;
  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic [FILL_W-1:0]   mf_r, mf_nxt, ff_r, ff_nxt, gf_r, gf_nxt;
  logic [IDX_W-1:0]    fo_r, fo_nxt, go_r, go_nxt;
  logic [CNT_W-1:0]    hits_r, hits_nxt, miss_r, miss_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  loc_t                loc_r, loc_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  loc_t                scan_loc_r, scan_loc_nxt;
  logic [FILL_W-1:0]   scan_i_r, scan_i_nxt;
  loc_t                sh_loc_r, sh_loc_nxt;
  logic [IDX_W-1:0]    sh_base_r, sh_base_nxt, sh_i_r, sh_i_nxt;
  logic [FILL_W-1:0]   sh_fill_r, sh_fill_nxt;
  aft_t                aft_r, aft_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [1:0]          out_found_r, out_found_nxt;
  logic [CNT_W-1:0]    out_hits_r, out_hits_nxt, out_miss_r, out_miss_nxt;

  logic                we, re;
  logic [MEM_AW-1:0]   waddr, raddr;
  logic [PAGE_W-1:0]   wdata, rdata;

  logic [CAP_W-1:0]    cap_e;
  logic [FILL_W-1:0]   msize, fsize, scan_fill;
  logic [IDX_W-1:0]    scan_base;
  logic                is_hit;

  tqpr_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (PAGE_W),
    .AW    (MEM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (cap_r < CAP_MIN) begin
      cap_e = CAP_MIN;
    end else if (cap_r > CAP_MAX) begin
      cap_e = CAP_MAX;
    end else begin
      cap_e = cap_r;
    end
  end

  assign msize  = FILL_W'(({1'b0, cap_e} + 7'd1) >> 1);
  assign fsize  = FILL_W'(cap_e >> 1);
  assign is_hit = (loc_r == LOC_MAIN) || (loc_r == LOC_FIFO);

  always_comb begin
    case (scan_loc_r)
      LOC_MAIN: begin
        scan_fill = mf_r;
        scan_base = '0;
      end
      LOC_FIFO: begin
        scan_fill = ff_r;
        scan_base = fo_r;
      end
      default: begin
        scan_fill = gf_r;
        scan_base = go_r;
      end
    endcase
  end

  // A capacity write wins over an access offered in the same cycle.
  assign in_stall  = !rst_n || cfg_valid || (state_r != ST_IDLE);
  assign cfg_ready = rst_n && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    mf_nxt        = mf_r;
    ff_nxt        = ff_r;
    gf_nxt        = gf_r;
    fo_nxt        = fo_r;
    go_nxt        = go_r;
    hits_nxt      = hits_r;
    miss_nxt      = miss_r;
    page_nxt      = page_r;
    loc_nxt       = loc_r;
    pos_nxt       = pos_r;
    scan_loc_nxt  = scan_loc_r;
    scan_i_nxt    = scan_i_r;
    sh_loc_nxt    = sh_loc_r;
    sh_base_nxt   = sh_base_r;
    sh_i_nxt      = sh_i_r;
    sh_fill_nxt   = sh_fill_r;
    aft_nxt       = aft_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_found_nxt = out_found_r;
    out_hits_nxt  = out_hits_r;
    out_miss_nxt  = out_miss_r;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          // A capacity write restarts the block with empty lists.
          cap_nxt  = cfg_data;
          mf_nxt   = '0;
          ff_nxt   = '0;
          gf_nxt   = '0;
          fo_nxt   = '0;
          go_nxt   = '0;
          hits_nxt = '0;
          miss_nxt = '0;
        end else if (in_valid) begin
          page_nxt     = in_page;
          scan_loc_nxt = LOC_MAIN;
          scan_i_nxt   = '0;
          state_nxt    = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        if (scan_i_r < scan_fill) begin
          re        = 1'b1;
          raddr     = mem_addr(scan_loc_r, IDX_W'(scan_base + scan_i_r[IDX_W-1:0]));
          state_nxt = ST_SC_CMP;
        end else if (scan_loc_r == LOC_GHOST) begin
          loc_nxt   = LOC_NONE;
          state_nxt = ST_ACT;
        end else begin
          scan_loc_nxt = (scan_loc_r == LOC_MAIN) ? LOC_FIFO : LOC_GHOST;
          scan_i_nxt   = '0;
        end
      end
      ST_SC_CMP: begin
        if (rdata == page_r) begin
          loc_nxt   = scan_loc_r;
          pos_nxt   = scan_i_r[IDX_W-1:0];
          state_nxt = ST_ACT;
        end else begin
          scan_i_nxt = scan_i_r + 1'b1;
          state_nxt  = ST_SC_RD;
        end
      end
      ST_ACT: begin
        case (loc_r)
          LOC_MAIN: begin
            sh_loc_nxt  = LOC_MAIN;
            sh_base_nxt = '0;
            sh_i_nxt    = pos_r;
            sh_fill_nxt = mf_r;
            aft_nxt     = AFT_MAIN_FIN;
            state_nxt   = ST_SH_RD;
          end
          LOC_FIFO: begin
            state_nxt = ST_DONE;
          end
          LOC_GHOST: begin
            sh_loc_nxt  = LOC_GHOST;
            sh_base_nxt = go_r;
            sh_i_nxt    = pos_r;
            sh_fill_nxt = gf_r;
            aft_nxt     = AFT_GHOST;
            state_nxt   = ST_SH_RD;
          end
          default: begin
            state_nxt = (ff_r >= fsize) ? ST_FI_RD : ST_FIN;
          end
        endcase
      end
      ST_SH_RD: begin
        if (({1'b0, sh_i_r} + 1'b1) < sh_fill_r) begin
          re        = 1'b1;
          raddr     = mem_addr(sh_loc_r, IDX_W'(sh_base_r + sh_i_r + 1'b1));
          state_nxt = ST_SH_WR;
        end else begin
          case (aft_r)
            AFT_GHOST: begin
              gf_nxt = gf_r - 1'b1;
              if (mf_r >= msize) begin
                // Main list is full: close the gap left by its oldest page.
                sh_loc_nxt  = LOC_MAIN;
                sh_base_nxt = '0;
                sh_i_nxt    = '0;
                sh_fill_nxt = mf_r;
                aft_nxt     = AFT_EVICT;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            AFT_EVICT: begin
              mf_nxt    = mf_r - 1'b1;
              state_nxt = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SH_WR: begin
        we        = 1'b1;
        waddr     = mem_addr(sh_loc_r, IDX_W'(sh_base_r + sh_i_r));
        sh_i_nxt  = sh_i_r + 1'b1;
        state_nxt = ST_SH_RD;
      end
      ST_FI_RD: begin
        re        = 1'b1;
        raddr     = mem_addr(LOC_FIFO, fo_r);
        state_nxt = ST_FI_WR;
      end
      ST_FI_WR: begin
        // The first-in head goes to the ghost tail. When the ghost list is
        // full, its oldest page is dropped by advancing the ghost head.
        fo_nxt = fo_r + 1'b1;
        ff_nxt = ff_r - 1'b1;
        we     = 1'b1;
        waddr  = mem_addr(LOC_GHOST, IDX_W'(go_r + gf_r[IDX_W-1:0]));
        if (gf_r >= msize) begin
          go_nxt = go_r + 1'b1;
        end else begin
          gf_nxt = gf_r + 1'b1;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        we    = 1'b1;
        wdata = page_r;
        case (loc_r)
          LOC_MAIN: begin
            waddr = mem_addr(LOC_MAIN, IDX_W'(mf_r - 1'b1));
          end
          LOC_GHOST: begin
            waddr  = mem_addr(LOC_MAIN, mf_r[IDX_W-1:0]);
            mf_nxt = mf_r + 1'b1;
          end
          default: begin
            waddr  = mem_addr(LOC_FIFO, IDX_W'(fo_r + ff_r[IDX_W-1:0]));
            ff_nxt = ff_r + 1'b1;
          end
        endcase
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (is_hit) begin
            hits_nxt = hits_r + CNT_W'(hits_r != '1);
          end else begin
            miss_nxt = miss_r + CNT_W'(miss_r != '1);
          end
          out_valid_nxt = 1'b1;
          out_hit_nxt   = is_hit;
          out_found_nxt = loc_r;
          out_hits_nxt  = is_hit ? hits_r + CNT_W'(hits_r != '1) : hits_r;
          out_miss_nxt  = is_hit ? miss_r : miss_r + CNT_W'(miss_r != '1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_MAX;
      mf_r        <= '0;
      ff_r        <= '0;
      gf_r        <= '0;
      fo_r        <= '0;
      go_r        <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      mf_r        <= mf_nxt;
      ff_r        <= ff_nxt;
      gf_r        <= gf_nxt;
      fo_r        <= fo_nxt;
      go_r        <= go_nxt;
      hits_r      <= hits_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    loc_r       <= loc_nxt;
    pos_r       <= pos_nxt;
    scan_loc_r  <= scan_loc_nxt;
    scan_i_r    <= scan_i_nxt;
    sh_loc_r    <= sh_loc_nxt;
    sh_base_r   <= sh_base_nxt;
    sh_i_r      <= sh_i_nxt;
    sh_fill_r   <= sh_fill_nxt;
    aft_r       <= aft_nxt;
    out_hit_r   <= out_hit_nxt;
    out_found_r <= out_found_nxt;
    out_hits_r  <= out_hits_nxt;
    out_miss_r  <= out_miss_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_found_in   = out_found_r;
  assign out_hit_total  = out_hits_r;
  assign out_miss_total = out_miss_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mf_r <= FILL_W'(LIST_DEPTH)) && (ff_r <= FILL_W'(LIST_DEPTH)) &&
    (gf_r <= FILL_W'(LIST_DEPTH)))
    else $error("list fill count beyond list depth");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the completion step");

  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re))
    else $error("memory read and write in the same cycle");

  a_transfer_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !cfg_valid) |=> (state_r == ST_SC_RD))
    else $error("accepted access did not start a lookup");
`endif

endmodule

[dv/two_queue_page_replacement_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_page_replacement_tb
// Self-checking bench for the 2Q page replacement block. A directed table
// and randomized phases over many capacities run through a queue-based
// model of the main, first-in and ghost lists; every result is compared
// field by field with the table's outcome for typed rows, else the model's.
// ----------------------------------------------------------------------------
module two_queue_page_replacement_tb;
  import tqpr_pkg::*;

  localparam int MAX_CYCLES = 2000000;
  localparam int DRAIN      = 200;
  localparam int PHASE_LEN  = 172;

  typedef struct packed {
    logic             hit;
    loc_t             found;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } outcome_t;

  typedef struct {
    logic              is_cfg;
    logic [PAGE_W-1:0] val;
    logic              typed;
    outcome_t          want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [PAGE_W-1:0] in_page;
  logic out_valid;
  logic out_stall;
  logic out_hit;
  logic [1:0] out_found_in;
  logic [CNT_W-1:0] out_hit_total;
  logic [CNT_W-1:0] out_miss_total;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  two_queue_page_replacement dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_page(in_page),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_found_in(out_found_in), .out_hit_total(out_hit_total),
    .out_miss_total(out_miss_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Model state of the three lists, oldest entry at the front.
  logic [PAGE_W-1:0] main_list[$];
  logic [PAGE_W-1:0] fifo_list[$];
  logic [PAGE_W-1:0] ghost_list[$];
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  miss_count;
  logic [CAP_W-1:0]  cap_reg;

  outcome_t pending[$];
  int mismatches;
  int results_seen;
  int found_seen[4];
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_request;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_model();
    main_list.delete();
    fifo_list.delete();
    ghost_list.delete();
    hit_count = '0;
    miss_count = '0;
  endfunction

  function automatic outcome_t replace_page(logic [PAGE_W-1:0] page);
    int cap;
    int main_sz;
    int fifo_sz;
    int idx;
    outcome_t r;
    logic [PAGE_W-1:0] head;
    cap = cap_reg;
    if (cap < CAP_MIN) cap = CAP_MIN;
    if (cap > CAP_MAX) cap = CAP_MAX;
    main_sz = (cap + 1) / 2;
    fifo_sz = cap / 2;
    r.found = LOC_NONE;
    idx = -1;
    foreach (main_list[i]) if (idx < 0 && main_list[i] == page) idx = i;
    if (idx >= 0) begin
      r.found = LOC_MAIN;
      main_list.delete(idx);
      main_list.push_back(page);
    end else begin
      foreach (fifo_list[i]) if (fifo_list[i] == page) r.found = LOC_FIFO;
      if (r.found == LOC_NONE) begin
        foreach (ghost_list[i]) if (idx < 0 && ghost_list[i] == page) idx = i;
        if (idx >= 0) begin
          r.found = LOC_GHOST;
          ghost_list.delete(idx);
          if (main_list.size() >= main_sz) void'(main_list.pop_front());
          main_list.push_back(page);
        end else begin
          if (fifo_list.size() >= fifo_sz) begin
            head = fifo_list.pop_front();
            if (ghost_list.size() >= main_sz) void'(ghost_list.pop_front());
            ghost_list.push_back(head);
          end
          fifo_list.push_back(page);
        end
      end
    end
    r.hit = (r.found == LOC_MAIN || r.found == LOC_FIFO);
    if (r.hit) begin
      if (hit_count != '1) hit_count++;
    end else begin
      if (miss_count != '1) miss_count++;
    end
    r.hits = hit_count;
    r.misses = miss_count;
    return r;
  endfunction

  // Offers one page, holding it until the block takes the transfer. The
  // stall is sampled at the falling edge, where it is stable.
  task automatic send_page(logic [PAGE_W-1:0] page, logic typed, outcome_t want);
    logic stalled;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page <= page;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (typed) pending.push_back(want);
    else pending.push_back(replace_page(page));
    if (typed) void'(replace_page(page));
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    logic ready;
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
    end while (!ready);
    cfg_valid <= 1'b0;
    cap_reg = value;
    clear_model();
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin : result_check
    outcome_t got;
    outcome_t exp_r;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.hit = out_hit;
        got.found = loc_t'(out_found_in);
        got.hits = out_hit_total;
        got.misses = out_miss_total;
        @(posedge clk);
        results_seen++;
        found_seen[got.found]++;
        if (pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
        end else begin
          exp_r = pending.pop_front();
          if (got.hit !== exp_r.hit || got.found !== exp_r.found ||
              got.hits !== exp_r.hits || got.misses !== exp_r.misses) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at result %0d: expected %p, got %p",
                       results_seen, exp_r, got);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", MAX_CYCLES);
    $display("FAIL");
    $finish;
  end

  // Directed table: typed rows cover reset state, field extremes and the
  // smallest capacity; the rest go through the model.
  row_t plan[] = '{
    '{1'b0, 32'h0000_0000, 1'b1, '{1'b0, LOC_NONE, 32'd0, 32'd1}},
    '{1'b0, 32'h0000_0000, 1'b1, '{1'b1, LOC_FIFO, 32'd1, 32'd1}},
    '{1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b0, LOC_NONE, 32'd1, 32'd2}},
    '{1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b1, LOC_FIFO, 32'd2, 32'd2}},
    '{1'b1, 32'd2,         1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h0000_0005, 1'b1, '{1'b0, LOC_NONE, 32'd0, 32'd1}},
    '{1'b0, 32'hA5A5_A5A5, 1'b1, '{1'b0, LOC_NONE, 32'd0, 32'd2}},
    '{1'b0, 32'h0000_0005, 1'b1, '{1'b0, LOC_GHOST, 32'd0, 32'd3}},
    '{1'b0, 32'h0000_0005, 1'b1, '{1'b1, LOC_MAIN, 32'd1, 32'd3}},
    '{1'b0, 32'h5A5A_5A5A, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'hA5A5_A5A5, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h0000_0005, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h5A5A_5A5A, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b1, 32'd0,         1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h0000_0001, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h0000_0002, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h0000_0001, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b1, 32'd63,        1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h8000_0000, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}},
    '{1'b0, 32'h8000_0000, 1'b0, '{1'b0, LOC_NONE, 32'd0, 32'd0}}
  };

  logic [CAP_W-1:0] phase_caps[9] = '{6'd32, 6'd2, 6'd1, 6'd5, 6'd33, 6'd17,
                                       6'd3, 6'd0, 6'd24};

  initial begin : stimulus
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] page;
    outcome_t none;
    logic [CAP_W-1:0] cap;
    int span;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_page = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 0;
    hold_left = 0;
    mismatches = 0;
    results_seen = 0;
    none = '0;
    cap_reg = CAP_MAX;
    clear_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_capacity(plan[i].val[CAP_W-1:0]);
      else send_page(plan[i].val, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 9; p++) begin
      tx_idle_pct = (p < 3) ? 25 : (p < 6) ? 49 : 0;
      rx_idle_pct = (p < 3) ? 49 : (p < 6) ? 25 : 0;
      cap = (p == 8) ? 6'($urandom_range(2, 63)) : phase_caps[p];
      write_capacity(cap);
      base = $urandom();
      span = (cap < CAP_MIN) ? 6 : 3 * cap;
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Mostly a small working set so pages cycle through all three lists.
        if ($urandom_range(9) < 8) page = base ^ PAGE_W'($urandom_range(span));
        else page = $urandom();
        if (p == 6 && n == 20) hold_request = 400;
        send_page(page, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("Covered %0d results over 13 capacity settings: main %0d, first-in %0d,",
             results_seen, found_seen[LOC_MAIN], found_seen[LOC_FIFO]);
    $display("ghost %0d, new %0d; %0d mismatches", found_seen[LOC_GHOST],
             found_seen[LOC_NONE], mismatches);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tqpr_pkg.sv
hw/rtl/tqpr_ram.sv
hw/rtl/two_queue_page_replacement.sv
dv/two_queue_page_replacement_tb.sv
